/* hdl/rar_pkg.sv */
// Package: payload types, command codes and the control program of the fraction unit.
package rar_pkg;

   // Input item: command and two signed fractions.
   typedef struct packed {
      logic [2:0]         command;
      logic signed [15:0] a_num;
      logic signed [15:0] a_den;
      logic signed [15:0] b_num;
      logic signed [15:0] b_den;
   } req_type;

   // Result item: reduced fraction and zero-denominator flag.
   typedef struct packed {
      logic signed [32:0] res_num;
      logic signed [31:0] res_den;
      logic               zero_den;
   } rsp_type;

   localparam logic [2:0] CMD_ADD = 3'd0;
   localparam logic [2:0] CMD_SUB = 3'd1;
   localparam logic [2:0] CMD_MUL = 3'd2;
   localparam logic [2:0] CMD_DIV = 3'd3;
   localparam logic [2:0] CMD_NEG = 3'd4;

   // Datapath operation of one control word.
   typedef enum logic [4:0] {
      OP_NOP,
      OP_LATCH,
      OP_MUL,
      OP_MUL_LDN,
      OP_MUL_ACC,
      OP_LDD,
      OP_GCD_INIT,
      OP_GCD_TWOS,
      OP_GCD_STEP,
      OP_GCD_SHL,
      OP_DIV_INIT_N,
      OP_DIV_STEP,
      OP_STORE_N,
      OP_DIV_INIT_D,
      OP_STORE_D,
      OP_NEGATE,
      OP_BAD,
      OP_EMIT
   } op_type;

   // Jump condition: taken jumps to target, else advance by one.
   typedef enum logic [3:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_REQ,
      C_NEGATE,
      C_BAD_CMD,
      C_DZERO,
      C_BOTH_EVEN,
      C_X_NZ,
      C_K_NZ,
      C_DIV_MORE,
      C_OUT_FREE
   } cond_type;

   // Product picked for the shared multiplier.
   typedef enum logic [1:0] {
      MS_NUM1,
      MS_NUM2,
      MS_DEN
   } sel_type;

   localparam int PC_W = 5;

   typedef struct packed {
      op_type          op;
      cond_type        cond;
      sel_type         sel;
      logic [PC_W-1:0] target;
   } uword_type;

   localparam logic [PC_W-1:0] PC_WAIT    = 5'd0;
   localparam logic [PC_W-1:0] PC_TWOS    = 5'd8;
   localparam logic [PC_W-1:0] PC_STEP    = 5'd9;
   localparam logic [PC_W-1:0] PC_SHL     = 5'd10;
   localparam logic [PC_W-1:0] PC_DIV_N   = 5'd12;
   localparam logic [PC_W-1:0] PC_DIV_D   = 5'd15;
   localparam logic [PC_W-1:0] PC_NEGATE  = 5'd17;
   localparam logic [PC_W-1:0] PC_BAD     = 5'd18;
   localparam logic [PC_W-1:0] PC_OUTPUT  = 5'd19;

   function automatic uword_type ucode_rom(input logic [PC_W-1:0] pc);
      uword_type w;
      w = '{op: OP_NOP, cond: C_ALWAYS, sel: MS_NUM1, target: PC_WAIT};
      case (pc)
         5'd0:  w = '{op: OP_LATCH,     cond: C_NO_REQ,    sel: MS_NUM1, target: PC_WAIT};
         5'd1:  w = '{op: OP_NOP,       cond: C_NEGATE,    sel: MS_NUM1, target: PC_NEGATE};
         5'd2:  w = '{op: OP_NOP,       cond: C_BAD_CMD,   sel: MS_NUM1, target: PC_BAD};
         5'd3:  w = '{op: OP_MUL,       cond: C_NEVER,     sel: MS_NUM1, target: PC_WAIT};
         5'd4:  w = '{op: OP_MUL_LDN,   cond: C_NEVER,     sel: MS_NUM2, target: PC_WAIT};
         5'd5:  w = '{op: OP_MUL_ACC,   cond: C_NEVER,     sel: MS_DEN,  target: PC_WAIT};
         5'd6:  w = '{op: OP_LDD,       cond: C_NEVER,     sel: MS_NUM1, target: PC_WAIT};
         5'd7:  w = '{op: OP_GCD_INIT,  cond: C_DZERO,     sel: MS_NUM1, target: PC_OUTPUT};
         5'd8:  w = '{op: OP_GCD_TWOS,  cond: C_BOTH_EVEN, sel: MS_NUM1, target: PC_TWOS};
         5'd9:  w = '{op: OP_GCD_STEP,  cond: C_X_NZ,      sel: MS_NUM1, target: PC_STEP};
         5'd10: w = '{op: OP_GCD_SHL,   cond: C_K_NZ,      sel: MS_NUM1, target: PC_SHL};
         5'd11: w = '{op: OP_DIV_INIT_N, cond: C_NEVER,    sel: MS_NUM1, target: PC_WAIT};
         5'd12: w = '{op: OP_DIV_STEP,  cond: C_DIV_MORE,  sel: MS_NUM1, target: PC_DIV_N};
         5'd13: w = '{op: OP_STORE_N,   cond: C_NEVER,     sel: MS_NUM1, target: PC_WAIT};
         5'd14: w = '{op: OP_DIV_INIT_D, cond: C_NEVER,    sel: MS_NUM1, target: PC_WAIT};
         5'd15: w = '{op: OP_DIV_STEP,  cond: C_DIV_MORE,  sel: MS_NUM1, target: PC_DIV_D};
         5'd16: w = '{op: OP_STORE_D,   cond: C_ALWAYS,    sel: MS_NUM1, target: PC_OUTPUT};
         5'd17: w = '{op: OP_NEGATE,    cond: C_ALWAYS,    sel: MS_NUM1, target: PC_OUTPUT};
         5'd18: w = '{op: OP_BAD,       cond: C_NEVER,     sel: MS_NUM1, target: PC_WAIT};
         5'd19: w = '{op: OP_EMIT,      cond: C_OUT_FREE,  sel: MS_NUM1, target: PC_WAIT};
         5'd20: w = '{op: OP_NOP,       cond: C_ALWAYS,    sel: MS_NUM1, target: PC_OUTPUT};
         default: w = '{op: OP_NOP,     cond: C_ALWAYS,    sel: MS_NUM1, target: PC_WAIT};
      endcase
      return w;
   endfunction

endpackage

/* hdl/rational_arith_reduce_unit.sv */
// Top level: microcoded fraction arithmetic unit with binary GCD reduction.
// The time per reduced item is set by the binary GCD loop and two bit-serial divides.
// Negate, unused commands and zero denominators skip the GCD loop and the divides.
// Throughput: one item at a time; the next item is taken once the result is in the output register.
// Reset: synchronous, active high; clears the program counter and the output valid.
module rational_arith_reduce_unit #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rar_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rar_pkg::rsp_type rsp_data
);
   import rar_pkg::*;

   localparam int W  = OPERAND_WIDTH;
   // Internal fraction width: exact up to 2W+1 bits, wraps at 64 like the arithmetic spec.
   localparam int XW = (2 * W + 1 > 64) ? 64 : 2 * W + 1;
   localparam int KW = $clog2(XW + 1);
   localparam int CW = $clog2(XW);

   // Sequencer
   logic [PC_W-1:0] pc_ff, pc_in;
   uword_type       uw;

   // Operand and datapath registers
   req_type               req_ff, req_in;
   logic signed [XW-1:0]  p_ff, p_in;   // registered product
   logic signed [XW-1:0]  n_ff, n_in;   // working numerator
   logic signed [XW-1:0]  d_ff, d_in;   // working denominator
   logic [XW-1:0]         x_ff, x_in;   // GCD operands; y ends as the divisor
   logic [XW-1:0]         y_ff, y_in;
   logic [KW-1:0]         k_ff, k_in;   // common factors of two
   logic [XW-1:0]         rem_ff, rem_in;
   logic [XW-1:0]         q_ff, q_in;   // dividend shifting out, quotient shifting in
   logic [CW-1:0]         cnt_ff, cnt_in;

   // Output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic signed [W-1:0]   an_s, ad_s, bn_s, bd_s;
   logic signed [W-1:0]   mul_a, mul_b;
   logic signed [2*W-1:0] prod;
   logic [2:0]            cmd;
   logic [XW-1:0]         mag_n, mag_d;
   logic [XW-1:0]         rem_sh;
   logic                  div_fit;
   logic signed [63:0]    n_wide, d_wide;
   logic                  out_free, req_fire, take;

   assign req_ready = (pc_ff == PC_WAIT);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign uw  = ucode_rom(pc_ff);
   assign cmd = req_ff.command;

   // Field bits zero-extend or truncate to W, then read as signed W-bit operands.
   assign an_s = W'($unsigned(req_ff.a_num));
   assign ad_s = W'($unsigned(req_ff.a_den));
   assign bn_s = W'($unsigned(req_ff.b_num));
   assign bd_s = W'($unsigned(req_ff.b_den));

   // Shared multiplier: pick the product asked for by the control word and command.
   always_comb begin
      mul_a = an_s;
      mul_b = bd_s;
      case (uw.sel)
         MS_NUM1: begin
            mul_a = an_s;
            mul_b = (cmd == CMD_MUL) ? bn_s : bd_s;
         end
         MS_NUM2: begin
            mul_a = bn_s;
            mul_b = ad_s;
         end
         MS_DEN: begin
            mul_a = ad_s;
            mul_b = (cmd == CMD_DIV) ? bn_s : bd_s;
         end
         default: begin
            mul_a = an_s;
            mul_b = bd_s;
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   assign mag_n = n_ff[XW-1] ? XW'(-n_ff) : XW'(n_ff);
   assign mag_d = d_ff[XW-1] ? XW'(-d_ff) : XW'(d_ff);

   // Divisor stays below 2^(XW-1), so the partial remainder never needs its top bit.
   assign rem_sh  = {rem_ff[XW-2:0], q_ff[XW-1]};
   assign div_fit = (rem_sh >= y_ff);

   assign n_wide = 64'(n_ff);
   assign d_wide = 64'(d_ff);

   // Next step: jump on the selected condition, else advance.
   always_comb begin
      take = 1'b0;
      case (uw.cond)
         C_NEVER:     take = 1'b0;
         C_ALWAYS:    take = 1'b1;
         C_NO_REQ:    take = !req_valid;
         C_NEGATE:    take = (cmd == CMD_NEG);
         C_BAD_CMD:   take = (cmd > CMD_NEG);
         C_DZERO:     take = (d_ff == '0);
         C_BOTH_EVEN: take = !x_ff[0] && !y_ff[0];
         C_X_NZ:      take = (x_ff != '0);
         C_K_NZ:      take = (k_ff != '0);
         C_DIV_MORE:  take = (cnt_ff != CW'(XW - 1));
         C_OUT_FREE:  take = out_free;
         default:     take = 1'b0;
      endcase
      pc_in = take ? uw.target : pc_ff + 1'b1;
   end

   // Datapath: one operation per step.
   always_comb begin
      req_in       = req_ff;
      p_in         = p_ff;
      n_in         = n_ff;
      d_in         = d_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      k_in         = k_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      cnt_in       = cnt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (uw.op)
         OP_NOP: begin
         end
         OP_LATCH: begin
            if (req_fire) begin
               req_in = req_data;
            end
         end
         OP_MUL: begin
            p_in = XW'(prod);
         end
         OP_MUL_LDN: begin
            n_in = p_ff;
            p_in = XW'(prod);
         end
         OP_MUL_ACC: begin
            // Add and subtract fold in the second cross product.
            if (cmd == CMD_ADD) begin
               n_in = n_ff + p_ff;
            end else if (cmd == CMD_SUB) begin
               n_in = n_ff - p_ff;
            end
            p_in = XW'(prod);
         end
         OP_LDD: begin
            d_in = p_ff;
         end
         OP_GCD_INIT: begin
            x_in = mag_n;
            y_in = mag_d;
            k_in = '0;
         end
         OP_GCD_TWOS: begin
            // Strip factors of two common to both.
            if (!x_ff[0] && !y_ff[0]) begin
               x_in = x_ff >> 1;
               y_in = y_ff >> 1;
               k_in = k_ff + 1'b1;
            end
         end
         OP_GCD_STEP: begin
            if (x_ff != '0) begin
               if (!x_ff[0]) begin
                  x_in = x_ff >> 1;
               end else if (!y_ff[0]) begin
                  y_in = y_ff >> 1;
               end else if (x_ff >= y_ff) begin
                  x_in = (x_ff - y_ff) >> 1;
               end else begin
                  y_in = (y_ff - x_ff) >> 1;
               end
            end
         end
         OP_GCD_SHL: begin
            // Restore the common twos: y becomes the GCD.
            if (k_ff != '0) begin
               y_in = y_ff << 1;
               k_in = k_ff - 1'b1;
            end
         end
         OP_DIV_INIT_N: begin
            rem_in = '0;
            q_in   = mag_n;
            cnt_in = '0;
         end
         OP_DIV_INIT_D: begin
            rem_in = '0;
            q_in   = mag_d;
            cnt_in = '0;
         end
         OP_DIV_STEP: begin
            if (div_fit) begin
               rem_in = rem_sh - y_ff;
            end else begin
               rem_in = rem_sh;
            end
            q_in   = {q_ff[XW-2:0], div_fit};
            cnt_in = cnt_ff + 1'b1;
         end
         OP_STORE_N: begin
            n_in = n_ff[XW-1] ? -$signed(q_ff) : $signed(q_ff);
         end
         OP_STORE_D: begin
            d_in = d_ff[XW-1] ? -$signed(q_ff) : $signed(q_ff);
         end
         OP_NEGATE: begin
            // Flip only the numerator; no reduction.
            n_in = -XW'(an_s);
            d_in = XW'(ad_s);
         end
         OP_BAD: begin
            n_in = '0;
            d_in = XW'(1);
         end
         OP_EMIT: begin
            // Hold until the output register is free.
            if (out_free) begin
               rsp_in.res_num  = n_wide[32:0];
               rsp_in.res_den  = d_wide[31:0];
               rsp_in.zero_den = (d_ff == '0);
               rsp_valid_in    = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= PC_WAIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      p_ff   <= p_in;
      n_ff   <= n_in;
      d_ff   <= d_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      k_ff   <= k_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      rsp_ff <= rsp_in;
   end

endmodule
